// ===== design/fsim_pkg.sv =====
// ----------------------------------------------------------------------------
// fsim_pkg
// Shared constants for the floppy sector interleave mapper: disk limits,
// register indexes, reset values and datapath widths.
// ----------------------------------------------------------------------------
package fsim_pkg;

	localparam int MAX_TRACKS  = 256;
	localparam int MAX_SECTORS = 64;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 9;

	typedef enum logic [CFG_ADDR_W-1:0] {
		REG_TRACK_COUNT       = 3'd0,
		REG_SECTORS_PER_TRACK = 3'd1,
		REG_INTERLEAVE_FACTOR = 3'd2,
		REG_SKEW_PER_TRACK    = 3'd3,
		REG_KEEP_TRACK_ZERO   = 3'd4
	} reg_idx_t;

	localparam logic [8:0] RST_TRACK_COUNT       = 9'd77;
	localparam logic [6:0] RST_SECTORS_PER_TRACK = 7'd26;
	localparam logic [5:0] RST_INTERLEAVE_FACTOR = 6'd2;
	localparam logic [7:0] RST_SKEW_PER_TRACK    = 8'd6;
	localparam logic       RST_KEEP_TRACK_ZERO   = 1'b0;

	// shared divider: dividend, divisor and step counter widths
	localparam int DIV_NUM_W = 17;
	localparam int DIV_DEN_W = 12;
	localparam int DIV_CNT_W = 5;

	// shared multiplier operand widths
	localparam int MUL_A_W = 9;
	localparam int MUL_B_W = 8;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

endpackage

// ===== design/floppy_sector_interleave_mapper.sv =====
// ----------------------------------------------------------------------------
// floppy_sector_interleave_mapper
// Maps a logical block number to physical block, track and sector of a
// single-sided floppy, with sector interleave, per-track skew and an
// optional shift of tracks by one. All divisions and modulos go through
// one shared restoring divider; products through one small multiplier.
// ----------------------------------------------------------------------------
//  channel   signals                                    handshake
//  --------  -----------------------------------------  -----------------------
//  request   logical_block                              start & !busy
//  result    physical_block, physical_track,            done (one cycle)
//            physical_sector, request_error
//  config    cfg_addr, cfg_wdata                        cfg_we
//
//  A refused request (bad configuration or block beyond disk) is answered
//  from the check state. A good request takes 3 divider passes; after a
//  configuration write the next good request adds one divider pass per
//  Euclid step and one for the lcm.
//  busy is high from acceptance until done; the result word cannot be
//  stalled. arst_n clears the sequencer, the cache valid bit and the
//  registers to their reset values.
// ----------------------------------------------------------------------------
module floppy_sector_interleave_mapper (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [13:0]                      logical_block,
	output logic                             done,
	output logic [13:0]                      physical_block,
	output logic [7:0]                       physical_track,
	output logic [5:0]                       physical_sector,
	output logic                             request_error,
	input  logic                             cfg_we,
	input  logic [fsim_pkg::CFG_ADDR_W-1:0]  cfg_addr,
	input  logic [fsim_pkg::CFG_DATA_W-1:0]  cfg_wdata
);

	typedef enum logic [3:0] {
		S_IDLE,
		S_CHK,
		S_GCD,
		S_LCM,
		S_TRK,
		S_MUL,
		S_CYC,
		S_SKEW,
		S_SEC,
		S_PBN
	} state_t;

	state_t state_q;

	// configuration
	logic [8:0] track_count_q;
	logic [6:0] sectors_q;
	logic [5:0] interleave_q;
	logic [7:0] skew_q;
	logic       keep_zero_q;

	logic [11:0] cycle_len_q;
	logic        cycle_valid_q;

	// request datapath
	logic [13:0]                     lbn_q;
	logic [fsim_pkg::MUL_P_W-1:0]    prod_q;
	logic [6:0]                      gcd_b_q;
	logic [7:0]                      trk_q;
	logic [5:0]                      idx_q;
	logic [5:0]                      sec_q;
	logic [fsim_pkg::DIV_NUM_W-1:0]  sum_q;

	// shared divider
	logic [fsim_pkg::DIV_NUM_W-1:0]  dv_quo_q;
	logic [fsim_pkg::DIV_DEN_W-1:0]  dv_rem_q;
	logic [fsim_pkg::DIV_DEN_W-1:0]  dv_den_q;
	logic [fsim_pkg::DIV_CNT_W-1:0]  dv_cnt_q;
	logic [fsim_pkg::DIV_DEN_W:0]    dv_rsh;
	logic                            dv_ge;
	logic [fsim_pkg::DIV_DEN_W-1:0]  dv_rem_nx;
	logic [fsim_pkg::DIV_NUM_W-1:0]  dv_quo_nx;
	logic                            dv_run;

	// shared multiplier
	logic [fsim_pkg::MUL_A_W-1:0]    mul_a;
	logic [fsim_pkg::MUL_B_W-1:0]    mul_b;
	logic [fsim_pkg::MUL_P_W-1:0]    mul_p;

	logic                            cfg_bad;
	logic [fsim_pkg::DIV_NUM_W-1:0]  skew_sum;
	logic [7:0]                      trk_next;
	logic [8:0]                      trk_inc;

	localparam logic [fsim_pkg::DIV_CNT_W-1:0] DIV_STEPS =
		fsim_pkg::DIV_CNT_W'(fsim_pkg::DIV_NUM_W);
	localparam logic [fsim_pkg::DIV_CNT_W-1:0] DIV_ONE =
		fsim_pkg::DIV_CNT_W'(1);

	assign busy = (state_q != S_IDLE);

	// one restoring step per cycle
	assign dv_run    = (dv_cnt_q != '0);
	assign dv_rsh    = {dv_rem_q, dv_quo_q[fsim_pkg::DIV_NUM_W-1]};
	assign dv_ge     = (dv_rsh >= {1'b0, dv_den_q});
	assign dv_rem_nx = dv_ge ? fsim_pkg::DIV_DEN_W'(dv_rsh - {1'b0, dv_den_q})
	                         : dv_rsh[fsim_pkg::DIV_DEN_W-1:0];
	assign dv_quo_nx = {dv_quo_q[fsim_pkg::DIV_NUM_W-2:0], dv_ge};

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		unique case (state_q)
			S_IDLE: begin
				mul_a = track_count_q;
				mul_b = {1'b0, sectors_q};
			end
			S_GCD: begin
				mul_a = {2'b0, sectors_q};
				mul_b = {2'b0, interleave_q};
			end
			S_MUL: begin
				mul_a = {3'b0, idx_q};
				mul_b = {2'b0, interleave_q};
			end
			S_SKEW: begin
				mul_a = {1'b0, trk_q};
				mul_b = skew_q;
			end
			S_PBN: begin
				mul_a = {1'b0, trk_q};
				mul_b = {1'b0, sectors_q};
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = fsim_pkg::MUL_P_W'(mul_a) * fsim_pkg::MUL_P_W'(mul_b);

	assign cfg_bad = (track_count_q == '0) ||
	                 (10'(track_count_q) > 10'(fsim_pkg::MAX_TRACKS)) ||
	                 (sectors_q == '0) ||
	                 (9'(sectors_q) > 9'(fsim_pkg::MAX_SECTORS)) ||
	                 (interleave_q == '0) ||
	                 ({1'b0, interleave_q} >= sectors_q);

	assign skew_sum = sum_q + mul_p;
	assign trk_inc  = {1'b0, trk_q} + 9'd1;
	assign trk_next = keep_zero_q ? trk_q :
	                  ((trk_inc == track_count_q) ? 8'd0 : trk_inc[7:0]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			track_count_q   <= fsim_pkg::RST_TRACK_COUNT;
			sectors_q       <= fsim_pkg::RST_SECTORS_PER_TRACK;
			interleave_q    <= fsim_pkg::RST_INTERLEAVE_FACTOR;
			skew_q          <= fsim_pkg::RST_SKEW_PER_TRACK;
			keep_zero_q     <= fsim_pkg::RST_KEEP_TRACK_ZERO;
			cycle_valid_q   <= 1'b0;
			cycle_len_q     <= '0;
			lbn_q           <= '0;
			prod_q          <= '0;
			gcd_b_q         <= '0;
			trk_q           <= '0;
			idx_q           <= '0;
			sec_q           <= '0;
			sum_q           <= '0;
			dv_quo_q        <= '0;
			dv_rem_q        <= '0;
			dv_den_q        <= '0;
			dv_cnt_q        <= '0;
			done            <= 1'b0;
			physical_block  <= '0;
			physical_track  <= '0;
			physical_sector <= '0;
			request_error   <= 1'b0;
		end else begin
			done <= 1'b0;

			if (cfg_we) begin
				unique case (cfg_addr)
					fsim_pkg::REG_TRACK_COUNT: begin
						track_count_q <= cfg_wdata;
						cycle_valid_q <= 1'b0;
					end
					fsim_pkg::REG_SECTORS_PER_TRACK: begin
						sectors_q     <= cfg_wdata[6:0];
						cycle_valid_q <= 1'b0;
					end
					fsim_pkg::REG_INTERLEAVE_FACTOR: begin
						interleave_q  <= cfg_wdata[5:0];
						cycle_valid_q <= 1'b0;
					end
					fsim_pkg::REG_SKEW_PER_TRACK: begin
						skew_q        <= cfg_wdata[7:0];
						cycle_valid_q <= 1'b0;
					end
					fsim_pkg::REG_KEEP_TRACK_ZERO: begin
						keep_zero_q   <= cfg_wdata[0];
						cycle_valid_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end

			if (dv_run) begin
				dv_rem_q <= dv_rem_nx;
				dv_quo_q <= dv_quo_nx;
				dv_cnt_q <= dv_cnt_q - DIV_ONE;
			end

			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						lbn_q   <= logical_block;
						prod_q  <= mul_p;
						state_q <= S_CHK;
					end
				end
				S_CHK: begin
					if (cfg_bad || ({3'b0, lbn_q} >= prod_q)) begin
						physical_block  <= '0;
						physical_track  <= '0;
						physical_sector <= '0;
						request_error   <= 1'b1;
						done            <= 1'b1;
						state_q         <= S_IDLE;
					end else if (cycle_valid_q) begin
						dv_quo_q <= {3'b0, lbn_q};
						dv_rem_q <= '0;
						dv_den_q <= {5'b0, sectors_q};
						dv_cnt_q <= DIV_STEPS;
						state_q  <= S_TRK;
					end else begin
						gcd_b_q  <= {1'b0, interleave_q};
						dv_quo_q <= {10'b0, sectors_q};
						dv_rem_q <= '0;
						dv_den_q <= {6'b0, interleave_q};
						dv_cnt_q <= DIV_STEPS;
						state_q  <= S_GCD;
					end
				end
				S_GCD: begin
					if (!dv_run) begin
						dv_rem_q <= '0;
						dv_cnt_q <= DIV_STEPS;
						if (dv_rem_q == '0) begin
							// gcd found, lcm = secs * il / gcd
							dv_quo_q <= mul_p;
							dv_den_q <= {5'b0, gcd_b_q};
							state_q  <= S_LCM;
						end else begin
							gcd_b_q  <= dv_rem_q[6:0];
							dv_quo_q <= {10'b0, gcd_b_q};
							dv_den_q <= dv_rem_q;
						end
					end
				end
				S_LCM: begin
					if (!dv_run) begin
						cycle_len_q   <= dv_quo_q[11:0];
						cycle_valid_q <= 1'b1;
						dv_quo_q      <= {3'b0, lbn_q};
						dv_rem_q      <= '0;
						dv_den_q      <= {5'b0, sectors_q};
						dv_cnt_q      <= DIV_STEPS;
						state_q       <= S_TRK;
					end
				end
				S_TRK: begin
					if (!dv_run) begin
						trk_q   <= dv_quo_q[7:0];
						idx_q   <= dv_rem_q[5:0];
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					sum_q    <= mul_p;
					dv_quo_q <= mul_p;
					dv_rem_q <= '0;
					dv_den_q <= cycle_len_q;
					dv_cnt_q <= DIV_STEPS;
					state_q  <= S_CYC;
				end
				S_CYC: begin
					if (!dv_run) begin
						sum_q   <= sum_q + dv_quo_q;
						state_q <= S_SKEW;
					end
				end
				S_SKEW: begin
					dv_quo_q <= skew_sum;
					dv_rem_q <= '0;
					dv_den_q <= {5'b0, sectors_q};
					dv_cnt_q <= DIV_STEPS;
					state_q  <= S_SEC;
				end
				S_SEC: begin
					if (!dv_run) begin
						sec_q   <= dv_rem_q[5:0];
						trk_q   <= trk_next;
						state_q <= S_PBN;
					end
				end
				S_PBN: begin
					physical_block  <= 14'(mul_p + {11'b0, sec_q});
					physical_track  <= trk_q;
					physical_sector <= sec_q;
					request_error   <= 1'b0;
					done            <= 1'b1;
					state_q         <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// result word only after the sequencer has returned to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while sequencer busy");

	// one result word per request
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result word repeated");

	// accepted request keeps the block busy
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("request accepted but block not busy");

	// refused request carries zero fields
	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && request_error) |->
			(physical_block == '0 && physical_track == '0 && physical_sector == '0))
		else $error("refused request with nonzero fields");

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives logical block numbers into the floppy sector interleave mapper under
// a series of disk geometries, predicts (or takes from a directed row) every
// physical block, track, sector and error flag, and checks each result against it.
// ----------------------------------------------------------------------------
module testbench;

	localparam logic [fsim_pkg::CFG_ADDR_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [fsim_pkg::CFG_ADDR_W-1:0] REG_SPARE_LAST  = 3'd7;

	typedef struct {
		logic [13:0] blk;
		logic [7:0]  trk;
		logic [5:0]  sec;
		logic        err;
	} mapping_t;

	typedef enum {ROW_WRITE, ROW_MAP} row_kind_t;

	typedef struct {
		row_kind_t                       kind;
		logic [fsim_pkg::CFG_ADDR_W-1:0] addr;
		logic [fsim_pkg::CFG_DATA_W-1:0] data;
		logic [13:0]                     lbn;
		bit                              known;
		mapping_t                        want;
	} script_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            start;
	logic                            busy;
	logic [13:0]                     logical_block;
	logic                            done;
	logic [13:0]                     physical_block;
	logic [7:0]                      physical_track;
	logic [5:0]                      physical_sector;
	logic                            request_error;
	logic                            cfg_we;
	logic [fsim_pkg::CFG_ADDR_W-1:0] cfg_addr;
	logic [fsim_pkg::CFG_DATA_W-1:0] cfg_wdata;

	// predictor copy of the registers and the lcm cache
	logic [8:0]  cur_tracks;
	logic [6:0]  cur_sectors;
	logic [5:0]  cur_interleave;
	logic [7:0]  cur_skew;
	logic        cur_keep;
	int unsigned lcm_len;
	bit          lcm_valid;

	mapping_t    pending_maps[$];
	mapping_t    got_word;
	mapping_t    no_map;
	script_row_t directed_rows[$];
	int          mismatches = 0;
	int          blocks_sent = 0;
	int          sender_idle_pct = 31;

	floppy_sector_interleave_mapper uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.logical_block   (logical_block),
		.done            (done),
		.physical_block  (physical_block),
		.physical_track  (physical_track),
		.physical_sector (physical_sector),
		.request_error   (request_error),
		.cfg_we          (cfg_we),
		.cfg_addr        (cfg_addr),
		.cfg_wdata       (cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic mapping_t map_block(logic [13:0] lbn);
		int unsigned tc, spt, ilv, a, b, trk, idx, s;
		mapping_t m;
		tc  = cur_tracks;
		spt = cur_sectors;
		ilv = cur_interleave;
		m   = '{default: '0};
		if (tc < 1 || tc > fsim_pkg::MAX_TRACKS || spt < 1 ||
				spt > fsim_pkg::MAX_SECTORS ||
				ilv < 1 || ilv >= spt || lbn >= tc * spt) begin
			m.err = 1'b1;
			return m;
		end
		if (!lcm_valid) begin
			a = spt;
			b = ilv;
			while (a != 0 && b != 0) begin
				if (a > b)
					a = a % b;
				else
					b = b % a;
			end
			lcm_len   = spt * ilv / (a + b);
			lcm_valid = 1'b1;
		end
		trk = lbn / spt;
		idx = lbn % spt;
		s   = idx * ilv;
		s   = s + s / lcm_len;
		s   = s + trk * cur_skew;
		s   = s % spt;
		if (!cur_keep)
			trk = trk + 1;
		trk   = trk % tc;
		m.blk = 14'(trk * spt + s);
		m.trk = 8'(trk);
		m.sec = 6'(s);
		return m;
	endfunction

	function automatic void note_write(logic [fsim_pkg::CFG_ADDR_W-1:0] addr,
			logic [fsim_pkg::CFG_DATA_W-1:0] data);
		bit hit;
		hit = 1'b1;
		case (addr)
			fsim_pkg::REG_TRACK_COUNT:       cur_tracks     = data[8:0];
			fsim_pkg::REG_SECTORS_PER_TRACK: cur_sectors    = data[6:0];
			fsim_pkg::REG_INTERLEAVE_FACTOR: cur_interleave = data[5:0];
			fsim_pkg::REG_SKEW_PER_TRACK:    cur_skew       = data[7:0];
			fsim_pkg::REG_KEEP_TRACK_ZERO:   cur_keep       = data[0];
			default:                         hit            = 1'b0;
		endcase
		if (hit)
			lcm_valid = 1'b0;
	endfunction

	function automatic script_row_t write_row(logic [fsim_pkg::CFG_ADDR_W-1:0] addr,
			logic [fsim_pkg::CFG_DATA_W-1:0] data);
		script_row_t r;
		r.kind  = ROW_WRITE;
		r.addr  = addr;
		r.data  = data;
		r.lbn   = '0;
		r.known = 1'b0;
		r.want  = '{default: '0};
		return r;
	endfunction

	function automatic script_row_t map_row(logic [13:0] lbn);
		script_row_t r;
		r       = write_row(fsim_pkg::REG_TRACK_COUNT, '0);
		r.kind  = ROW_MAP;
		r.lbn   = lbn;
		return r;
	endfunction

	function automatic script_row_t known_row(logic [13:0] lbn, logic [13:0] blk,
			logic [7:0] trk, logic [5:0] sec, logic err);
		script_row_t r;
		r          = map_row(lbn);
		r.known    = 1'b1;
		r.want.blk = blk;
		r.want.trk = trk;
		r.want.sec = sec;
		r.want.err = err;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		$display("mismatch at %0t: %s got %0d want %0d", $realtime, what, got, want);
	endtask

	task automatic send_block(input logic [13:0] lbn, input bit known,
			input mapping_t want);
		mapping_t m;
		start         <= 1'b1;
		logical_block <= lbn;
		do @(posedge clk); while (busy !== 1'b0);
		m = map_block(lbn);
		pending_maps.push_back(known ? want : m);
		blocks_sent++;
		if ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		do @(negedge clk); while (pending_maps.size() != 0 || busy !== 1'b0);
		@(posedge clk);
	endtask

	task automatic write_reg(input logic [fsim_pkg::CFG_ADDR_W-1:0] addr,
			input logic [fsim_pkg::CFG_DATA_W-1:0] data);
		cfg_we    <= 1'b1;
		cfg_addr  <= addr;
		cfg_wdata <= data;
		@(posedge clk);
		note_write(addr, data);
	endtask

	// result word checker
	always @(posedge clk) begin
		if (arst_n === 1'b1 && done !== 1'b0) begin
			if (pending_maps.size() == 0) begin
				report_mismatch("unexpected result word, block", physical_block, 0);
			end else begin
				got_word = pending_maps.pop_front();
				if (physical_block !== got_word.blk)
					report_mismatch("physical_block", physical_block, got_word.blk);
				if (physical_track !== got_word.trk)
					report_mismatch("physical_track", physical_track, got_word.trk);
				if (physical_sector !== got_word.sec)
					report_mismatch("physical_sector", physical_sector, got_word.sec);
				if (request_error !== got_word.err)
					report_mismatch("request_error", request_error, got_word.err);
			end
		end
	end

	initial begin
		#5_000_000;
		$display("FAIL");
		$finish;
	end

	initial begin
		int          phase, pick, n;
		int unsigned tc, spt, ilv, skew, keep, disk, rnd_block;
		logic [8:0]  junk;

		arst_n         <= 1'b0;
		start          <= 1'b0;
		logical_block  <= '0;
		cfg_we         <= 1'b0;
		cfg_addr       <= '0;
		cfg_wdata      <= '0;
		cur_tracks     = fsim_pkg::RST_TRACK_COUNT;
		cur_sectors    = fsim_pkg::RST_SECTORS_PER_TRACK;
		cur_interleave = fsim_pkg::RST_INTERLEAVE_FACTOR;
		cur_skew       = fsim_pkg::RST_SKEW_PER_TRACK;
		cur_keep       = fsim_pkg::RST_KEEP_TRACK_ZERO;
		lcm_len        = 0;
		lcm_valid      = 1'b0;
		no_map         = '{default: '0};

		// reset geometry: 77 tracks, 26 sectors, interleave 2, skew 6
		directed_rows.push_back(known_row(14'd0, 14'd26, 8'd1, 6'd0, 1'b0));
		directed_rows.push_back(map_row(14'd2001));
		directed_rows.push_back(known_row(14'd2002, '0, '0, '0, 1'b1));
		directed_rows.push_back(known_row(14'd16383, '0, '0, '0, 1'b1));
		directed_rows.push_back(map_row(14'd13));
		directed_rows.push_back(map_row(14'd1000));
		directed_rows.push_back(write_row(fsim_pkg::REG_KEEP_TRACK_ZERO, 9'd1));
		directed_rows.push_back(known_row(14'd0, '0, '0, '0, 1'b0));
		directed_rows.push_back(map_row(14'd1999));
		// write to an unused index is dropped
		directed_rows.push_back(write_row(REG_SPARE_FIRST, 9'h1FF));
		directed_rows.push_back(map_row(14'd1999));
		directed_rows.push_back(write_row(fsim_pkg::REG_TRACK_COUNT, 9'd0));
		directed_rows.push_back(known_row(14'd0, '0, '0, '0, 1'b1));
		directed_rows.push_back(write_row(fsim_pkg::REG_TRACK_COUNT, 9'd257));
		directed_rows.push_back(known_row(14'd0, '0, '0, '0, 1'b1));
		// largest disk, every block in range
		directed_rows.push_back(write_row(fsim_pkg::REG_TRACK_COUNT, 9'd256));
		directed_rows.push_back(write_row(fsim_pkg::REG_SECTORS_PER_TRACK, 9'd64));
		directed_rows.push_back(write_row(fsim_pkg::REG_INTERLEAVE_FACTOR, 9'd63));
		directed_rows.push_back(write_row(fsim_pkg::REG_SKEW_PER_TRACK, 9'd255));
		directed_rows.push_back(map_row(14'd16383));
		directed_rows.push_back(known_row(14'd0, '0, '0, '0, 1'b0));
		directed_rows.push_back(map_row(14'd8191));
		directed_rows.push_back(write_row(fsim_pkg::REG_KEEP_TRACK_ZERO, 9'd0));
		directed_rows.push_back(map_row(14'd16383));
		directed_rows.push_back(write_row(fsim_pkg::REG_SECTORS_PER_TRACK, 9'd65));
		directed_rows.push_back(known_row(14'd1, '0, '0, '0, 1'b1));
		directed_rows.push_back(write_row(fsim_pkg::REG_SECTORS_PER_TRACK, 9'd0));
		directed_rows.push_back(known_row(14'd1, '0, '0, '0, 1'b1));
		// interleave equal to sectors
		directed_rows.push_back(write_row(fsim_pkg::REG_SECTORS_PER_TRACK, 9'd63));
		directed_rows.push_back(known_row(14'd1, '0, '0, '0, 1'b1));
		directed_rows.push_back(write_row(fsim_pkg::REG_INTERLEAVE_FACTOR, 9'd0));
		directed_rows.push_back(known_row(14'd1, '0, '0, '0, 1'b1));
		// smallest disk
		directed_rows.push_back(write_row(fsim_pkg::REG_TRACK_COUNT, 9'd1));
		directed_rows.push_back(write_row(fsim_pkg::REG_SECTORS_PER_TRACK, 9'd2));
		directed_rows.push_back(write_row(fsim_pkg::REG_INTERLEAVE_FACTOR, 9'd1));
		directed_rows.push_back(write_row(fsim_pkg::REG_SKEW_PER_TRACK, 9'd0));
		directed_rows.push_back(map_row(14'd0));
		directed_rows.push_back(map_row(14'd1));
		directed_rows.push_back(known_row(14'd2, '0, '0, '0, 1'b1));
		directed_rows.push_back(write_row(REG_SPARE_LAST, 9'h0AA));
		directed_rows.push_back(map_row(14'd1));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_WRITE) begin
				wait_idle();
				write_reg(directed_rows[i].addr, directed_rows[i].data);
				cfg_we <= 1'b0;
			end else begin
				send_block(directed_rows[i].lbn, directed_rows[i].known,
					directed_rows[i].want);
			end
		end

		phase = 0;
		while (blocks_sent < 720) begin
			wait_idle();
			pick = (phase < 2) ? phase : $urandom_range(0, 9);
			case (pick)
				0: begin
					tc = 256; spt = 64; ilv = 63; skew = 255;
				end
				1: begin
					tc = 1; spt = 2; ilv = 1; skew = 0;
				end
				2: begin
					tc   = $urandom_range(0, 511);
					spt  = $urandom_range(0, 127);
					ilv  = $urandom_range(0, 63);
					skew = $urandom_range(0, 255);
				end
				default: begin
					tc   = $urandom_range(1, 256);
					spt  = $urandom_range(2, 64);
					ilv  = $urandom_range(1, spt - 1);
					skew = $urandom_range(0, 255);
				end
			endcase
			keep = $urandom_range(0, 1);
			junk = 9'($urandom);
			write_reg(fsim_pkg::REG_TRACK_COUNT, 9'(tc));
			write_reg(fsim_pkg::REG_SECTORS_PER_TRACK, {junk[8:7], 7'(spt)});
			write_reg(fsim_pkg::REG_INTERLEAVE_FACTOR, {junk[8:6], 6'(ilv)});
			write_reg(fsim_pkg::REG_SKEW_PER_TRACK, {junk[8], 8'(skew)});
			write_reg(fsim_pkg::REG_KEEP_TRACK_ZERO, {junk[8:1], 1'(keep)});
			if ($urandom_range(0, 3) == 0)
				write_reg(3'($urandom_range(REG_SPARE_FIRST, REG_SPARE_LAST)), 9'($urandom));
			cfg_we <= 1'b0;

			n = $urandom_range(10, 50);
			repeat (n) begin
				if (blocks_sent < 270)
					sender_idle_pct = 31;
				else if (blocks_sent < 520)
					sender_idle_pct = 65;
				else
					sender_idle_pct = 0;
				if ($urandom_range(0, 99) < 3)
					wait_idle();
				pick = $urandom_range(0, 99);
				disk = cur_tracks * cur_sectors;
				if (disk == 0 || pick < 8)
					rnd_block = $urandom_range(0, 16383);
				else if (pick < 14)
					rnd_block = (disk - pick % 2 > 16383) ? 16383 : disk - pick % 2;
				else
					rnd_block = $urandom_range(0, ((disk > 16384) ? 16384 : disk) - 1);
				send_block(14'(rnd_block), 1'b0, no_map);
			end
			phase++;
		end

		wait_idle();
		repeat (300) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
